>>> rtl/md2_pkg.sv
`timescale 1ns / 1ps

package md2_pkg;

    localparam int BLK    = 16;
    localparam int WIDE   = 48;
    localparam int ROUNDS = 18;
    localparam int K_W    = $clog2(WIDE);
    localparam int R_W    = $clog2(ROUNDS);
    localparam int F_W    = $clog2(BLK);
    localparam int PAD_W  = F_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUNDS,
        ST_OUT
    } md2_state_t;

    // which kind of block is being folded into the state
    typedef enum logic [1:0] {
        PH_MSG,
        PH_PADBLK,
        PH_FINAL
    } md2_phase_t;

    localparam logic [7:0] SBOX [256] = '{
        8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
        8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
        8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
        8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
        8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
        8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
        8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
        8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
        8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
        8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
        8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
        8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
        8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
        8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
        8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
        8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
        8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
        8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
        8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
        8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
        8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
        8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
        8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
        8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
        8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
        8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
        8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
        8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
        8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
        8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
        8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
        8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
    };

endpackage

>>> rtl/md2_if.sv
`timescale 1ns / 1ps

interface md2_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, output data_byte, output byte_valid, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input byte_valid, input last,
                    output ready);
endinterface

interface md2_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] digest_byte;
    logic       digest_last;

    modport source (output valid, output digest_byte, output digest_last, input ready);
    modport sink   (input valid, input digest_byte, input digest_last, output ready);
endinterface

>>> rtl/md2_hash_engine.sv
`timescale 1ns / 1ps

// MD2 digest engine (RFC 1319). Each input request may carry one message byte
// and an end mark. The 48-byte state is a rotating byte line passed through
// one S-table lookup per cycle. Every completed 16-byte block is first loaded
// (block bytes and checksum update shifted in) and then run through 18 rounds
// over the 48-byte state, during which no request is taken. On the end mark,
// padding appends 16 minus the pending byte count bytes (16 when none are
// pending), then the pad block and the checksum block are each loaded and run
// through the rounds in the same way, and the 16 digest bytes follow, byte 0
// first, one per accepted output request. After the last digest byte the
// state is clear for a new message.
module md2_hash_engine (
    input  logic      clk,
    input  logic      rst_n,
    md2_in_if.sink    in_ch,
    md2_out_if.source out_ch
);
    import md2_pkg::*;

    md2_state_t       state_reg, state_next;
    md2_phase_t       phase_reg, phase_next;

    logic [7:0]       h_reg [WIDE];
    logic [7:0]       h_next [WIDE];
    logic [7:0]       c_reg [BLK];
    logic [7:0]       c_next [BLK];
    logic [7:0]       m_reg [BLK];
    logic [7:0]       m_next [BLK];
    logic [7:0]       x_reg [BLK];
    logic [7:0]       x_next [BLK];

    logic [F_W-1:0]   fill_reg, fill_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [R_W-1:0]   r_reg, r_next;
    logic [7:0]       t_reg, t_next;
    logic [PAD_W-1:0] pad_reg, pad_next;
    logic             end_reg, end_next;

    logic             in_acc, out_acc, blk_full, k_last, r_last;
    logic [F_W-1:0]   fill_inc;
    logic [7:0]       src, sbox_idx, sbox_out, mixed, csum_new;

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign out_acc  = out_ch.valid && out_ch.ready;
    assign blk_full = in_acc && in_ch.byte_valid && (fill_reg == F_W'(BLK - 1));
    assign fill_inc = fill_reg + F_W'(in_ch.byte_valid);
    assign k_last   = (k_reg == K_W'(WIDE - 1));
    assign r_last   = (r_reg == R_W'(ROUNDS - 1));

    assign src      = (phase_reg == PH_FINAL) ? c_reg[0] : m_reg[0];
    assign sbox_idx = (state_reg == ST_LOAD) ? (m_reg[0] ^ t_reg) : t_reg;
    assign sbox_out = SBOX[sbox_idx];
    assign mixed    = h_reg[0] ^ sbox_out;
    assign csum_new = c_reg[0] ^ sbox_out;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (blk_full)
                    state_next = ST_LOAD;
                else if (in_acc && in_ch.last)
                    state_next = ST_PAD;
            end
            ST_PAD:
            begin
                if (fill_reg == F_W'(BLK - 1))
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (k_last)
                    state_next = ST_ROUNDS;
            end
            ST_ROUNDS:
            begin
                if (k_last && r_last)
                begin
                    unique case (phase_reg)
                        PH_MSG:    state_next = end_reg ? ST_PAD : ST_IDLE;
                        PH_PADBLK: state_next = ST_LOAD;
                        PH_FINAL:  state_next = ST_OUT;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OUT:
            begin
                if (out_acc && (k_reg[F_W-1:0] == F_W'(BLK - 1)))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_ch.ready        = (state_reg == ST_IDLE);
        out_ch.valid       = (state_reg == ST_OUT);
        out_ch.digest_byte = h_reg[0];
        out_ch.digest_last = (k_reg[F_W-1:0] == F_W'(BLK - 1));
    end

    // datapath
    always_comb
    begin
        h_next     = h_reg;
        c_next     = c_reg;
        m_next     = m_reg;
        x_next     = x_reg;
        fill_next  = fill_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        t_next     = t_reg;
        pad_next   = pad_reg;
        end_next   = end_reg;
        phase_next = phase_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_ch.byte_valid)
                    begin
                        for (int i = 0; i < BLK - 1; i++)
                            m_next[i] = m_reg[i+1];
                        m_next[BLK-1] = in_ch.data_byte;
                    end
                    fill_next  = fill_inc;
                    end_next   = in_ch.last;
                    phase_next = PH_MSG;
                    pad_next   = PAD_W'(BLK) - {1'b0, fill_inc};
                    t_next     = c_reg[BLK-1];
                    k_next     = '0;
                end
            end
            ST_PAD:
            begin
                for (int i = 0; i < BLK - 1; i++)
                    m_next[i] = m_reg[i+1];
                m_next[BLK-1] = 8'(pad_reg);
                fill_next     = fill_reg + F_W'(1);
                phase_next    = PH_PADBLK;
                t_next        = c_reg[BLK-1];
                k_next        = '0;
            end
            ST_LOAD:
            begin
                for (int i = 0; i < WIDE - 1; i++)
                    h_next[i] = h_reg[i+1];
                if (k_reg < K_W'(BLK))
                begin
                    // lower third passes through; stash block ^ state for the top third
                    h_next[WIDE-1] = h_reg[0];
                    for (int i = 0; i < BLK - 1; i++)
                        x_next[i] = x_reg[i+1];
                    x_next[BLK-1] = src ^ h_reg[0];
                    for (int i = 0; i < BLK - 1; i++)
                        c_next[i] = c_reg[i+1];
                    if (phase_reg == PH_FINAL)
                        c_next[BLK-1] = c_reg[0];
                    else
                    begin
                        c_next[BLK-1] = csum_new;
                        t_next        = csum_new;
                    end
                end
                else if (k_reg < K_W'(2 * BLK))
                begin
                    h_next[WIDE-1] = src;
                    if (phase_reg == PH_FINAL)
                    begin
                        for (int i = 0; i < BLK - 1; i++)
                            c_next[i] = c_reg[i+1];
                        c_next[BLK-1] = c_reg[0];
                    end
                end
                else
                begin
                    h_next[WIDE-1] = x_reg[0];
                    for (int i = 0; i < BLK - 1; i++)
                        x_next[i] = x_reg[i+1];
                    x_next[BLK-1] = x_reg[0];
                end
                if (k_reg < K_W'(2 * BLK))
                begin
                    for (int i = 0; i < BLK - 1; i++)
                        m_next[i] = m_reg[i+1];
                    m_next[BLK-1] = m_reg[0];
                end
                k_next = k_last ? '0 : k_reg + K_W'(1);
                if (k_last)
                begin
                    t_next = '0;
                    r_next = '0;
                end
            end
            ST_ROUNDS:
            begin
                for (int i = 0; i < WIDE - 1; i++)
                    h_next[i] = h_reg[i+1];
                h_next[WIDE-1] = mixed;
                t_next = mixed;
                k_next = k_last ? '0 : k_reg + K_W'(1);
                if (k_last)
                begin
                    t_next = mixed + 8'(r_reg);
                    r_next = r_last ? '0 : r_reg + R_W'(1);
                    if (r_last)
                    begin
                        unique case (phase_reg)
                            PH_MSG:
                            begin
                                pad_next = PAD_W'(BLK);
                                end_next = 1'b0;
                            end
                            PH_PADBLK:
                            begin
                                phase_next = PH_FINAL;
                                t_next     = c_reg[BLK-1];
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    for (int i = 0; i < WIDE - 1; i++)
                        h_next[i] = h_reg[i+1];
                    h_next[WIDE-1] = h_reg[0];
                    k_next = k_reg + K_W'(1);
                    if (k_reg[F_W-1:0] == F_W'(BLK - 1))
                    begin
                        for (int i = 0; i < WIDE; i++)
                            h_next[i] = '0;
                        for (int i = 0; i < BLK; i++)
                            c_next[i] = '0;
                        fill_next = '0;
                        k_next    = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_MSG;
            fill_reg  <= '0;
            k_reg     <= '0;
            r_reg     <= '0;
            end_reg   <= 1'b0;
            for (int i = 0; i < WIDE; i++)
                h_reg[i] <= '0;
            for (int i = 0; i < BLK; i++)
                c_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
            k_reg     <= k_next;
            r_reg     <= r_next;
            end_reg   <= end_next;
            h_reg     <= h_next;
            c_reg     <= c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        x_reg   <= x_next;
        t_reg   <= t_next;
        pad_reg <= pad_next;
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input taken while digest is streaming");

    a_load_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (fill_reg == '0))
        else $error("block load started with partial fill");

    a_rounds_hold_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUNDS) |=> $stable(fill_reg))
        else $error("fill count moved during rounds");

    a_out_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUNDS && state_next == ST_OUT) |-> (phase_reg == PH_FINAL))
        else $error("digest emitted before checksum block");

    a_clear_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && out_ch.digest_last) |=> (in_ch.ready && fill_reg == '0))
        else $error("engine not cleared after digest");

endmodule
